[rtl/core/fhr_pkg.sv]
`default_nettype none

package fhr_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CFG_FADE = 2'd0;
    localparam logic [1:0] CFG_HOLD = 2'd1;
    localparam logic [1:0] CFG_MASK = 2'd2;

    localparam logic [7:0] FULL_ALPHA = 8'd255;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_ZERO = 2'd0;
    localparam t_kind KIND_FULL = 2'd1;
    localparam t_kind KIND_UP   = 2'd2;
    localparam t_kind KIND_DOWN = 2'd3;

    typedef struct packed {
        logic [15:0] fade;
        logic [15:0] hold;
        logic [2:0]  mask;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] x;
        logic [1:0]  code;
        logic        active;
    } t_job;

endpackage

`default_nettype wire

[rtl/core/fade_hold_rotator.sv]
`default_nettype none

// Rotates through the display items enabled in item_mask and gives a fade
// level for each millisecond tick: ramp up over fade_time, full for hold_time,
// ramp down over fade_time, then the next enabled item. The front end takes
// one tick per cycle while the queue is not full, updates the rotation state
// and queues a job in a two-entry queue; the back end scales the phase time
// by 255 and divides by fade_time in an 8-step restoring divider. The back
// end pops a job only when idle: a fade tick goes through the divide state
// and then the done state, any other tick straight to the done state, and
// the result is registered to the output. Write configuration only while no
// tick is in flight; o_cfg_ready is always high.
module fade_hold_rotator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_now_ms,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_alpha,
    output logic             o_animating,
    output logic [1:0]       o_item_code,
    output logic             o_active,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import fhr_pkg::*;

    t_cfg       r_cfg;
    t_job       push_job;
    t_job       head_job;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    logic [1:0] q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fade <= 16'd500;
            r_cfg.hold <= 16'd3000;
            r_cfg.mask <= 3'd7;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FADE: r_cfg.fade <= i_cfg_data;
                CFG_HOLD: r_cfg.hold <= i_cfg_data;
                CFG_MASK: r_cfg.mask <= i_cfg_data[2:0];
                default:  r_cfg <= r_cfg;
            endcase
        end
    end

    fhr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_now_ms (i_now_ms),
        .i_cfg    (r_cfg),
        .i_full   (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    fhr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_level (q_level)
    );

    fhr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_fade      (r_cfg.fade),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_alpha     (o_alpha),
        .o_animating (o_animating),
        .o_item_code (o_item_code),
        .o_active    (o_active)
    );

    a_inactive_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_active) |-> (o_alpha == 8'd0 && !o_animating && o_item_code == 2'd0))
        else $error("inactive item not blank");

    a_item_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_active) |-> ((o_item_code == 2'd0 && r_cfg.mask[0]) ||
                                   (o_item_code == 2'd1 && r_cfg.mask[1]) ||
                                   (o_item_code == 2'd2 && r_cfg.mask[2])))
        else $error("shown item not enabled");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> (q_level != 2'(QUEUE_DEPTH)))
        else $error("tick accepted into full queue");

endmodule

`default_nettype wire

[rtl/core/fhr_front.sv]
`default_nettype none

module fhr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [31:0]   i_now_ms,
    input  wire fhr_pkg::t_cfg i_cfg,
    input  wire logic          i_full,
    output logic               o_push,
    output fhr_pkg::t_job      o_job
);
    import fhr_pkg::*;

    logic        r_started;
    logic [31:0] r_cycle_start;
    logic [1:0]  r_shown;

    logic [1:0]  count;
    logic [1:0]  pos;
    logic [1:0]  n_shown;
    logic [17:0] cycle;
    logic [16:0] fade_hold;
    logic [31:0] diff;
    logic        adv;
    logic        restart;
    logic [17:0] e;
    logic [17:0] e_down;
    logic        accept;

    function automatic logic [1:0] item_at(input logic [2:0] mask, input logic [1:0] p);
        logic [1:0] seen;
        logic [1:0] res;
        logic       found;
        seen  = 2'd0;
        res   = 2'd0;
        found = 1'b0;
        for (int b = 0; b < 3; b++) begin
            if (mask[b] && !found) begin
                if (seen == p) begin
                    res   = 2'(b);
                    found = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
        return res;
    endfunction

    assign count     = {1'b0, i_cfg.mask[0]} + {1'b0, i_cfg.mask[1]} + {1'b0, i_cfg.mask[2]};
    assign pos       = (r_shown < count) ? r_shown : 2'd0;
    assign cycle     = {1'b0, i_cfg.fade, 1'b0} + {2'b00, i_cfg.hold};
    assign fade_hold = {1'b0, i_cfg.fade} + {1'b0, i_cfg.hold};
    assign diff      = i_now_ms - r_cycle_start;
    assign adv       = r_started && (diff >= {14'd0, cycle});
    assign restart   = !r_started || adv;
    assign n_shown   = !adv ? pos : ((pos + 2'd1 == count) ? 2'd0 : pos + 2'd1);
    assign e         = restart ? 18'd0 : diff[17:0];
    assign e_down    = e - {1'b0, fade_hold};

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    always_comb begin
        o_job.kind   = KIND_ZERO;
        o_job.x      = 16'd0;
        o_job.code   = 2'd0;
        o_job.active = 1'b0;
        if (count != 2'd0) begin
            o_job.active = 1'b1;
            o_job.code   = item_at(i_cfg.mask, n_shown);
            priority if (e < {2'b00, i_cfg.fade}) begin
                o_job.kind = KIND_UP;
                o_job.x    = e[15:0];
            end else if (e < {1'b0, fade_hold}) begin
                o_job.kind = KIND_FULL;
            end else if (e < cycle) begin
                o_job.kind = KIND_DOWN;
                o_job.x    = e_down[15:0];
            end else begin
                o_job.kind = KIND_ZERO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started     <= 1'b0;
            r_cycle_start <= 32'd0;
            r_shown       <= 2'd0;
        end else if (accept && count != 2'd0) begin
            r_started <= 1'b1;
            r_shown   <= n_shown;
            if (restart) begin
                r_cycle_start <= i_now_ms;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/fhr_queue.sv]
`default_nettype none

module fhr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire fhr_pkg::t_job i_job,
    input  wire logic          i_pop,
    output fhr_pkg::t_job      o_job,
    output logic               o_full,
    output logic               o_empty,
    output logic [1:0]         o_level
);
    import fhr_pkg::*;

    t_job       r_slot [QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;

    assign o_job   = r_slot[r_rd_ptr];
    assign o_full  = (r_level == 2'(QUEUE_DEPTH));
    assign o_empty = (r_level == 2'd0);
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/fhr_back.sv]
`default_nettype none

module fhr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fhr_pkg::t_job i_job,
    input  wire logic          i_empty,
    output logic               o_pop,
    input  wire logic [15:0]   i_fade,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_alpha,
    output logic               o_animating,
    output logic [1:0]         o_item_code,
    output logic               o_active
);
    import fhr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  r_state;
    logic [2:0]  r_cnt;
    logic [15:0] r_rem;
    logic [7:0]  r_low;
    logic [7:0]  r_quo;
    t_kind       r_kind;
    logic [1:0]  r_code;
    logic        r_active;
    logic        r_valid;
    logic [7:0]  r_alpha;
    logic        r_anim;
    logic [1:0]  r_item;
    logic        r_act_out;

    logic [23:0] scaled;
    logic [16:0] trial;
    logic [16:0] trial_sub;
    logic        ge;
    logic        slot_free;
    logic [7:0]  n_alpha;

    assign scaled    = {i_job.x, 8'd0} - {8'd0, i_job.x};
    assign trial     = {r_rem, r_low[7]};
    assign trial_sub = trial - {1'b0, i_fade};
    assign ge        = (trial >= {1'b0, i_fade});
    assign slot_free = !r_valid || i_ready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        unique case (r_kind)
            KIND_ZERO: n_alpha = 8'd0;
            KIND_FULL: n_alpha = FULL_ALPHA;
            KIND_UP:   n_alpha = r_quo;
            KIND_DOWN: n_alpha = FULL_ALPHA - r_quo;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= i_job.kind;
            r_code   <= i_job.code;
            r_active <= i_job.active;
            r_rem    <= scaled[23:8];
            r_low    <= scaled[7:0];
            r_quo    <= 8'd0;
        end else if (r_state == S_DIV) begin
            r_rem <= ge ? trial_sub[15:0] : trial[15:0];
            r_low <= {r_low[6:0], 1'b0};
            r_quo <= {r_quo[6:0], ge};
        end
        if (r_state == S_DONE && slot_free) begin
            r_alpha   <= n_alpha;
            r_anim    <= (r_kind == KIND_UP) || (r_kind == KIND_DOWN);
            r_item    <= r_code;
            r_act_out <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && slot_free) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cnt   <= 3'd0;
                        r_state <= (i_job.kind == KIND_UP || i_job.kind == KIND_DOWN)
                                   ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_alpha     = r_alpha;
    assign o_animating = r_anim;
    assign o_item_code = r_item;
    assign o_active    = r_act_out;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fhr_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;

    typedef struct packed {
        logic [7:0] alpha;
        logic       animating;
        logic [1:0] item_code;
        logic       active;
    } t_fade_result;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_alpha;
    logic        o_animating;
    logic [1:0]  o_item_code;
    logic        o_active;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    fade_hold_rotator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_now_ms    (i_now_ms),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_alpha     (o_alpha),
        .o_animating (o_animating),
        .o_item_code (o_item_code),
        .o_active    (o_active),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // rotation state and registers as the block should hold them
    logic [15:0] m_fade = 16'd500;
    logic [15:0] m_hold = 16'd3000;
    logic [2:0]  m_mask = 3'b111;
    logic        m_started = 1'b0;
    logic [31:0] m_start = '0;
    logic [1:0]  m_idx = '0;

    t_fade_result fade_q[$];
    t_fade_result want;

    int n_errors = 0;
    int n_ticks = 0;
    int n_results = 0;
    int n_cfg = 0;
    int burst_left = 0;
    bit no_gaps = 1'b0;
    int idle_cycles = 0;

    logic [15:0] rx_pat = 16'hFFFF;
    bit          rx_free = 1'b1;
    int          rx_age = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [1:0] nth_enabled(logic [2:0] mask, logic [1:0] pos);
        logic [1:0] seen = 2'd0;
        for (int b = 0; b < 3; b++) begin
            if (mask[b]) begin
                if (seen == pos) return 2'(b);
                seen++;
            end
        end
        return 2'd0;
    endfunction

    function automatic logic [31:0] cycle_span();
        return {15'd0, m_fade, 1'b0} + {16'd0, m_hold};
    endfunction

    function automatic t_fade_result fade_predict(logic [31:0] now);
        t_fade_result r;
        logic [1:0]  cnt;
        logic [1:0]  pos;
        logic [31:0] span;
        logic [31:0] fade32;
        logic [31:0] fh;
        logic [31:0] e;
        r = '0;
        cnt = 2'($countones(m_mask));
        span = cycle_span();
        fade32 = {16'd0, m_fade};
        fh = fade32 + {16'd0, m_hold};
        if (cnt == 2'd0) return r;
        pos = (m_idx < cnt) ? m_idx : 2'd0;
        if (!m_started) begin
            m_start = now;
            m_started = 1'b1;
        end else if (now - m_start >= span) begin
            pos = (pos + 2'd1 == cnt) ? 2'd0 : pos + 2'd1;
            m_start = now;
        end
        m_idx = pos;
        e = now - m_start;
        if (e < fade32) begin
            r.alpha = 8'((e * 32'd255) / fade32);
            r.animating = 1'b1;
        end else if (e < fh) begin
            r.alpha = FULL_ALPHA;
        end else if (e < span) begin
            r.alpha = 8'(32'd255 - ((e - fh) * 32'd255) / fade32);
            r.animating = 1'b1;
        end
        r.item_code = nth_enabled(m_mask, pos);
        r.active = 1'b1;
        return r;
    endfunction

    task automatic send_tick(input logic [31:0] now);
        if (!no_gaps && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        fade_q.push_back(fade_predict(now));
        i_valid <= 1'b1;
        i_now_ms <= now;
        do @(posedge i_clk); while (!o_ready);
        n_ticks++;
    endtask

    task automatic send_at(input logic [31:0] offset);
        send_tick(m_start + offset);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (fade_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FADE: m_fade = data;
            CFG_HOLD: m_hold = data;
            CFG_MASK: m_mask = data[2:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    function automatic logic [31:0] pick_time();
        logic [31:0] span;
        logic [31:0] f;
        logic [31:0] h;
        span = cycle_span();
        f = {16'd0, m_fade};
        h = {16'd0, m_hold};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1, 2: begin
                case ($urandom_range(0, 5))
                    0: return m_start + f - 1;
                    1: return m_start + f;
                    2: return m_start + f + h - 1;
                    3: return m_start + f + h;
                    4: return m_start + span - 1;
                    default: return m_start + span;
                endcase
            end
            3: return m_start + span + $urandom_range(0, 3 * span + 3);
            default: return m_start + $urandom_range(0, span);
        endcase
    endfunction

    function automatic logic [15:0] pick_span_part(bit is_fade);
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return is_fade ? 16'd1 : 16'($urandom_range(0, 60));
            3, 4: return 16'($urandom_range(2, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_default_cycle();
        send_tick(32'hFFFF_FF00);
        send_at(32'd499);
        send_at(32'd500);
        send_at(32'd3499);
        send_at(32'd3500);
        send_at(32'd3999);
        send_at(32'd4000);
    endtask

    task automatic test_zero_fade();
        cfg_write(CFG_FADE, 16'd0);
        cfg_write(CFG_HOLD, 16'd10);
        send_at(32'd0);
        send_at(32'd9);
        send_at(32'd10);
    endtask

    task automatic test_mask_shrink();
        cfg_write(CFG_FADE, 16'd4);
        cfg_write(CFG_HOLD, 16'd4);
        while (m_idx != 2'd2) send_at(cycle_span());
        cfg_write(CFG_MASK, 16'hFFF9);
        cfg_write(CFG_SPARE, 16'hFFFF);
        send_at(32'd1);
        cfg_write(CFG_MASK, 16'h0006);
        send_at(cycle_span());
    endtask

    task automatic test_empty_mask();
        cfg_write(CFG_MASK, 16'h0000);
        send_tick($urandom);
        cfg_write(CFG_MASK, 16'h0007);
        send_at(32'd2);
    endtask

    task automatic test_extreme_times();
        cfg_write(CFG_FADE, 16'hFFFF);
        cfg_write(CFG_HOLD, 16'hFFFF);
        send_at(32'd65534);
        send_at(32'd131070);
        send_at(32'd196604);
        send_at(32'd196605);
        cfg_write(CFG_FADE, 16'd1);
        cfg_write(CFG_HOLD, 16'd0);
        send_at(32'd1);
        send_at(32'd2);
    endtask

    task automatic test_random_rotation();
        logic [2:0] mask;
        for (int ph = 0; ph < 8; ph++) begin
            mask = ($urandom_range(0, 15) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
            cfg_write(CFG_FADE, pick_span_part(1'b1));
            cfg_write(CFG_HOLD, pick_span_part(1'b0));
            cfg_write(CFG_MASK, {13'($urandom), mask});
            no_gaps = (ph == 3);
            for (int k = 0; k < 52; k++) send_tick(pick_time());
            drain_results();
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (rx_age == 0) begin
            rx_pat = 16'($urandom) | 16'h0001;
            rx_free = ($urandom_range(0, 3) == 0);
            rx_age = $urandom_range(40, 200);
        end
        rx_age--;
        rx_pat = {rx_pat[0], rx_pat[15:1]};
        i_ready <= rx_free || rx_pat[0];
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (fade_q.size() == 0) begin
                $error("item with no expected result");
                n_errors++;
            end else begin
                want = fade_q.pop_front();
                if (o_alpha !== want.alpha) begin
                    $error("alpha: expected %0d, got %0d", want.alpha, o_alpha);
                    n_errors++;
                end
                if (o_animating !== want.animating) begin
                    $error("animating: expected %0d, got %0d", want.animating, o_animating);
                    n_errors++;
                end
                if (o_item_code !== want.item_code) begin
                    $error("item_code: expected %0d, got %0d", want.item_code, o_item_code);
                    n_errors++;
                end
                if (o_active !== want.active) begin
                    $error("active: expected %0d, got %0d", want.active, o_active);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d results still outstanding", fade_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_cycle();
        test_zero_fade();
        test_mask_shrink();
        test_empty_mask();
        test_extreme_times();
        test_random_rotation();
        drain_results();
        if (fade_q.size() != 0) begin
            $error("%0d expected results never arrived", fade_q.size());
            n_errors++;
        end
        $display("Sent %0d ticks over %0d register writes, checked %0d results",
                 n_ticks, n_cfg, n_results);
        $display("Covered fade ramps, hold, wrap of the ms counter, empty and shrunk masks");
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/fhr_pkg.sv
rtl/core/fhr_front.sv
rtl/core/fhr_queue.sv
rtl/core/fhr_back.sv
rtl/core/fade_hold_rotator.sv
dv/tb_top.sv
